// File: hw/rtl/isbs_pkg.sv
// Shared types, codes and constants for the I2C slave byte sequencer.
package isbs_pkg;

    // Sequencer phases, one-hot.
    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_ADDR_ARM = 8'b0000_0010,
        PH_ADDR_CHK = 8'b0000_0100,
        PH_RX       = 8'b0000_1000,
        PH_RX_CHK   = 8'b0001_0000,
        PH_TX       = 8'b0010_0000,
        PH_TX_ACK   = 8'b0100_0000,
        PH_ACK_CHK  = 8'b1000_0000
    } phase_t;

    // Reported phase numbers.
    localparam logic [2:0] PHN_IDLE     = 3'd0;
    localparam logic [2:0] PHN_ADDR_ARM = 3'd1;
    localparam logic [2:0] PHN_ADDR_CHK = 3'd2;
    localparam logic [2:0] PHN_RX       = 3'd3;
    localparam logic [2:0] PHN_RX_CHK   = 3'd4;
    localparam logic [2:0] PHN_TX       = 3'd5;
    localparam logic [2:0] PHN_TX_ACK   = 3'd6;
    localparam logic [2:0] PHN_ACK_CHK  = 3'd7;

    localparam logic [7:0] ACK_BYTE  = 8'h00;
    localparam logic [7:0] NACK_BYTE = 8'hFF;

    localparam logic [3:0] CLK_NONE    = 4'd0;
    localparam logic [3:0] CLK_ACK_BIT = 4'd1;
    localparam logic [3:0] CLK_BYTE    = 4'd8;

    localparam logic [6:0] OWN_ADDRESS_RST     = 7'd72;
    localparam logic [7:0] BYTES_PER_WRITE_RST = 8'd1;

    // Register select, taken from address bit 2.
    localparam logic REG_OWN_ADDRESS     = 1'b0;
    localparam logic REG_BYTES_PER_WRITE = 1'b1;

    typedef struct packed {
        logic       start_seen;
        logic [7:0] shift_reg;
    } evt_t;

    typedef struct packed {
        logic       load_shift;
        logic [7:0] shift_value;
        logic [3:0] clock_bits;
        logic       sda_drive;
        logic       led_update;
        logic       led_level;
        logic [2:0] phase_now;
    } res_t;

    typedef struct packed {
        logic [6:0] own_address;
        logic [7:0] bytes_per_write;
    } cfg_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:     code = PHN_IDLE;
            PH_ADDR_ARM: code = PHN_ADDR_ARM;
            PH_ADDR_CHK: code = PHN_ADDR_CHK;
            PH_RX:       code = PHN_RX;
            PH_RX_CHK:   code = PHN_RX_CHK;
            PH_TX:       code = PHN_TX;
            PH_TX_ACK:   code = PHN_TX_ACK;
            PH_ACK_CHK:  code = PHN_ACK_CHK;
            default:     code = PHN_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: hw/rtl/isbs_if.sv
// Valid/ready channel interfaces for events in and results out.
interface isbs_evt_if;
    logic       valid;
    logic       ready;
    logic       start_seen;
    logic [7:0] shift_reg;

    modport source (output valid, output start_seen, output shift_reg, input ready);
    modport sink   (input valid, input start_seen, input shift_reg, output ready);
endinterface

interface isbs_res_if;
    logic       valid;
    logic       ready;
    logic       load_shift;
    logic [7:0] shift_value;
    logic [3:0] clock_bits;
    logic       sda_drive;
    logic       led_update;
    logic       led_level;
    logic [2:0] phase_now;

    modport source (
        output valid, output load_shift, output shift_value, output clock_bits,
        output sda_drive, output led_update, output led_level, output phase_now,
        input ready
    );
    modport sink (
        input valid, input load_shift, input shift_value, input clock_bits,
        input sda_drive, input led_update, input led_level, input phase_now,
        output ready
    );
endinterface

// File: hw/rtl/isbs_cfg_regs.sv
// APB-style configuration registers: own address and bytes per write.
module isbs_cfg_regs
    import isbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        reg_sel,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output cfg_t        cfg
);

    logic [6:0] own_address_reg;
    logic [7:0] bytes_per_write_reg;
    logic       wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg     <= OWN_ADDRESS_RST;
            bytes_per_write_reg <= BYTES_PER_WRITE_RST;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_OWN_ADDRESS)
            begin
                own_address_reg <= pwdata[6:0];
            end
            else
            begin
                bytes_per_write_reg <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == REG_OWN_ADDRESS)
        begin
            prdata = {25'd0, own_address_reg};
        end
        else
        begin
            prdata = {24'd0, bytes_per_write_reg};
        end
    end

    assign cfg.own_address     = own_address_reg;
    assign cfg.bytes_per_write = bytes_per_write_reg;

endmodule

// File: hw/rtl/isbs_in_stage.sv
// Input register stage: captures one event word and holds it for the sequencer.
module isbs_in_stage
    import isbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    isbs_evt_if.sink evt,
    input  logic take,
    output logic held_valid,
    output evt_t held
);

    logic valid_reg;
    evt_t data_reg;
    logic load;

    // Accept when empty or when the held word moves on this cycle.
    assign evt.ready = !valid_reg || take;
    assign load      = evt.valid && evt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.start_seen <= evt.start_seen;
            data_reg.shift_reg  <= evt.shift_reg;
        end
    end

    assign held_valid = valid_reg;
    assign held       = data_reg;

endmodule

// File: hw/rtl/isbs_seq_core.sv
// Sequencer state, next-state logic and the result register.
module isbs_seq_core
    import isbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic held_valid,
    input  evt_t held,
    output logic take,
    isbs_res_if.source res
);

    phase_t     phase_reg, phase_next, ph_cur;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] last_rx_reg, last_rx_next;
    logic       sda_reg, sda_next;
    logic       res_valid_reg;
    res_t       res_reg, res_next;
    logic [8:0] count_inc;

    assign take      = held_valid && (!res_valid_reg || res.ready);
    assign count_inc = {1'b0, byte_count_reg} + 9'd1;

    always_comb
    begin
        // A start overrides whatever phase was left behind.
        ph_cur          = held.start_seen ? PH_ADDR_ARM : phase_reg;
        phase_next      = ph_cur;
        byte_count_next = byte_count_reg;
        last_rx_next    = last_rx_reg;
        sda_next        = sda_reg;
        res_next        = '0;
        res_next.shift_value = ACK_BYTE;
        res_next.clock_bits  = CLK_NONE;

        case (ph_cur)
            PH_ADDR_ARM:
            begin
                res_next.clock_bits = CLK_BYTE;
                phase_next          = PH_ADDR_CHK;
            end
            PH_ADDR_CHK:
            begin
                sda_next            = 1'b1;
                res_next.load_shift = 1'b1;
                res_next.clock_bits = CLK_ACK_BIT;
                if (held.shift_reg[7:1] == cfg.own_address)
                begin
                    res_next.shift_value = ACK_BYTE;
                    phase_next = held.shift_reg[0] ? PH_TX : PH_RX;
                end
                else
                begin
                    res_next.shift_value = NACK_BYTE;
                    phase_next           = PH_RX_CHK;
                end
            end
            PH_RX:
            begin
                sda_next            = 1'b0;
                res_next.clock_bits = CLK_BYTE;
                phase_next          = PH_RX_CHK;
            end
            PH_RX_CHK:
            begin
                last_rx_next        = held.shift_reg;
                res_next.led_update = 1'b1;
                res_next.led_level  = held.shift_reg[0];
                res_next.load_shift = 1'b1;
                if (count_inc < {1'b0, cfg.bytes_per_write})
                begin
                    sda_next             = 1'b1;
                    res_next.shift_value = ACK_BYTE;
                    res_next.clock_bits  = CLK_ACK_BIT;
                    byte_count_next      = count_inc[7:0];
                    phase_next           = PH_RX;
                end
                else
                begin
                    // Last byte: load NACK but leave it unclocked, release SDA.
                    sda_next             = 1'b0;
                    res_next.shift_value = NACK_BYTE;
                    byte_count_next      = 8'd0;
                    phase_next           = PH_IDLE;
                end
            end
            PH_TX:
            begin
                sda_next             = 1'b1;
                res_next.load_shift  = 1'b1;
                res_next.shift_value = last_rx_reg;
                res_next.clock_bits  = CLK_BYTE;
                phase_next           = PH_TX_ACK;
            end
            PH_TX_ACK:
            begin
                sda_next            = 1'b0;
                res_next.clock_bits = CLK_ACK_BIT;
                phase_next          = PH_ACK_CHK;
            end
            PH_ACK_CHK:
            begin
                if (held.shift_reg[0])
                begin
                    // Master NACK ends the read.
                    sda_next        = 1'b0;
                    byte_count_next = 8'd0;
                    phase_next      = PH_IDLE;
                end
                else
                begin
                    sda_next             = 1'b1;
                    res_next.load_shift  = 1'b1;
                    res_next.shift_value = last_rx_reg;
                    res_next.clock_bits  = CLK_BYTE;
                    phase_next           = PH_TX_ACK;
                end
            end
            default:
            begin
                phase_next = ph_cur;
            end
        endcase

        res_next.sda_drive = sda_next;
        res_next.phase_now = phase_code(phase_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_count_reg <= 8'd0;
            last_rx_reg    <= 8'd0;
            sda_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg      <= phase_next;
                byte_count_reg <= byte_count_next;
                last_rx_reg    <= last_rx_next;
                sda_reg        <= sda_next;
                res_valid_reg  <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.load_shift  = res_reg.load_shift;
    assign res.shift_value = res_reg.shift_value;
    assign res.clock_bits  = res_reg.clock_bits;
    assign res.sda_drive   = res_reg.sda_drive;
    assign res.led_update  = res_reg.led_update;
    assign res.led_level   = res_reg.led_level;
    assign res.phase_now   = res_reg.phase_now;

endmodule

// File: hw/rtl/i2c_slave_byte_sequencer.sv
// Top level of the I2C slave byte sequencer.
//
//  channel | dir | handshake        | word
//  --------+-----+------------------+-----------------------------------------
//  evt     | in  | valid/ready      | start_seen, shift_reg
//  res     | out | valid/ready      | load_shift, shift_value, clock_bits,
//          |     |                  | sda_drive, led_update, led_level, phase_now
//  apb     | in  | psel/penable     | paddr[2] selects register, pwdata, prdata
//
// One event word enters per cycle unless the result stalls; it goes to the input register,
// then its result to the result register, so the sustained rate is one word per cycle.
// Sequencer state updates when a word moves from the input register to the result register.
// Reset clears the phase to idle, the byte count, the last byte and the SDA drive.
// A stalled result holds; the input register takes one more word, then ready drops
// until the result moves, so at most two words are in flight.
module i2c_slave_byte_sequencer
    import isbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    isbs_evt_if.sink    evt,
    isbs_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg;
    logic held_valid;
    evt_t held;
    logic take;

    assign pready = 1'b1;

    isbs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .reg_sel (paddr[2]),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    isbs_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .take       (take),
        .held_valid (held_valid),
        .held       (held)
    );

    isbs_seq_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .held_valid (held_valid),
        .held       (held),
        .take       (take),
        .res        (res)
    );

endmodule

// File: hw/rtl/isbs_checker.sv
// Port-level checker for the I2C slave byte sequencer, bound to the top level.
module isbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        evt_valid,
    input logic        evt_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [18:0] res_word,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    logic [1:0] inflight_reg;
    logic       evt_fire;
    logic       res_fire;
    logic       own_wr;

    assign evt_fire = evt_valid && evt_ready;
    assign res_fire = res_valid && res_ready;
    assign own_wr   = psel && penable && pwrite && !paddr[2];

    // Track words accepted but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else
        begin
            inflight_reg <= inflight_reg + {1'b0, evt_fire} - {1'b0, res_fire};
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_word))
        else $error("result word changed while stalled");

    a_inflight_max: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("more than two words in flight");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> inflight_reg != 2'd0)
        else $error("result shown without an accepted word");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

    a_addr_readback: assert property (@(posedge clk) disable iff (!rst_n)
        own_wr ##1 !paddr[2] |-> prdata[6:0] == $past(pwdata[6:0]))
        else $error("own address readback mismatch");

endmodule

bind i2c_slave_byte_sequencer isbs_checker u_isbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_word  ({res.load_shift, res.shift_value, res.clock_bits, res.sda_drive,
                 res.led_update, res.led_level, res.phase_now}),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
